/* rtl/lir_pkg.sv */
// Package for the linear interpolation resampler.
// Types, widths and constants shared by the front, back and blend modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int PHASE_W  = 21;

  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1 << FRAC_W);
  localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(1 << FRAC_W);

  // Queue between front and back; depth kept a power of two so pointers wrap.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One classified input item.
  typedef struct packed {
    sample_t sample;
    logic    prime;
  } q_entry_t;

  // One blend job from the sequencer to the datapath.
  typedef struct packed {
    sample_t           prev;
    sample_t           cur;
    logic [FRAC_W-1:0] t;
    logic              last;
  } blend_req_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/lir_front.sv */
// Front end: accepts input items, tags the priming sample, and queues them.
// Depends on lir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lir_front
  import lir_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sample_t  sample_in,
  output logic          q_valid,
  output q_entry_t      q_head,
  input  wire logic     q_pop
);

  q_entry_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              primed;
  logic              push;
  logic              pop;

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      primed <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
        primed <= 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].sample <= sample_in;
      entries[wr_ptr].prime  <= !primed;
    end
  end

endmodule

`default_nettype wire

/* rtl/lir_back.sv */
// Back end sequencer: owns the phase accumulator and previous sample, and
// issues one blend job per cycle (when req_ready) for each output of a run.
// Depends on lir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lir_back
  import lir_pkg::*;
#(
  parameter int MAX_RUN = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [PHASE_W-1:0] step,
  input  wire logic               q_valid,
  input  wire q_entry_t           q_head,
  output logic                    q_pop,
  output logic                    req_valid,
  output blend_req_t              req,
  input  wire logic               req_ready
);

  localparam int CNT_W = $clog2(MAX_RUN + 1);

  back_state_t        state, state_next;
  logic [PHASE_W-1:0] phase, phase_next;
  sample_t            prev_sample, prev_sample_next;
  sample_t            cur_sample, cur_sample_next;
  logic [CNT_W-1:0]   cnt, cnt_next;

  logic [PHASE_W:0]   sum;
  logic               sum_ge_one;
  logic               cap_hit;
  logic               is_last;

  assign sum        = {1'b0, phase} + {1'b0, step};
  assign sum_ge_one = |sum[PHASE_W:FRAC_W];
  assign cap_hit    = (cnt == CNT_W'(MAX_RUN - 1));
  assign is_last    = sum_ge_one || cap_hit;

  always_comb begin
    req.prev  = prev_sample;
    req.cur   = cur_sample;
    req.t     = phase[FRAC_W-1:0];
    req.last  = is_last;
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    prev_sample_next = prev_sample;
    cur_sample_next  = cur_sample;
    cnt_next         = cnt;
    q_pop            = 1'b0;
    req_valid        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.prime) begin
            prev_sample_next = q_head.sample;
          end else if (phase >= PHASE_ONE) begin
            // no output this item, phase just drops by one
            phase_next       = phase - PHASE_ONE;
            prev_sample_next = q_head.sample;
          end else begin
            cur_sample_next = q_head.sample;
            cnt_next        = '0;
            state_next      = BK_RUN;
          end
        end
      end
      BK_RUN: begin
        req_valid = 1'b1;
        if (req_ready) begin
          cnt_next = cnt + 1'b1;
          if (is_last) begin
            // sum >= one: phase = sum - one; cap hit below one: clamp to zero
            if (sum_ge_one) begin
              phase_next = PHASE_W'(sum - {1'b0, PHASE_ONE});
            end else begin
              phase_next = '0;
            end
            prev_sample_next = cur_sample;
            state_next       = BK_IDLE;
          end else begin
            phase_next = sum[PHASE_W-1:0];
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      phase       <= '0;
      prev_sample <= '0;
      cnt         <= '0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      prev_sample <= prev_sample_next;
      cnt         <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_sample <= cur_sample_next;
  end

endmodule

`default_nettype wire

/* rtl/lir_blend.sv */
// Blend datapath: prev + (cur - prev) * t, truncated toward zero.
// Multiply stage, then add/round stage into the output register.
// Depends on lir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lir_blend
  import lir_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire blend_req_t req,
  output logic            req_ready,
  output logic            out_valid,
  input  wire logic       out_stall,
  output sample_t         resampled,
  output logic            last
);

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;

  logic                     v1;
  logic signed [PROD_W-1:0] prod;
  sample_t                  prev1;
  logic                     last1;
  logic                     ready2;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [FRAC_W:0]     t_s;
  logic signed [PROD_W-1:0]   acc;
  logic signed [PROD_W-FRAC_W-1:0] quo;
  logic signed [PROD_W-FRAC_W-1:0] quo_adj;

  assign ready2    = !out_valid || !out_stall;
  assign req_ready = !v1 || ready2;

  assign diff = DIFF_W'(req.cur) - DIFF_W'(req.prev);
  assign t_s  = $signed({1'b0, req.t});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (req_ready) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      prod  <= PROD_W'(diff * t_s);
      prev1 <= req.prev;
      last1 <= req.last;
    end
  end

  // acc = prev * 2^16 + diff * t; divide by 2^16 rounding toward zero
  assign acc     = (PROD_W'(prev1) <<< FRAC_W) + prod;
  assign quo     = acc[PROD_W-1:FRAC_W];
  assign quo_adj = (acc[PROD_W-1] && (acc[FRAC_W-1:0] != '0)) ? quo + 1'b1 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      resampled <= quo_adj[SAMPLE_W-1:0];
      last      <= last1;
    end
  end

endmodule

`default_nettype wire

/* rtl/linear_interp_resampler_unit.sv */
// Top level of the linear interpolation resampler.
// Holds the step ratio register; instantiates lir_front, lir_back, lir_blend.
// Depends on lir_pkg.
//
//   channel   direction  handshake                    payload
//   input     in         in_valid / in_stall          sample_in
//   output    out        out_valid / out_stall        resampled, last
//   config    in         step_ratio_wr_en             step_ratio
//
// Each item takes one pop-and-classify step in the back sequencer, plus one
// blend job per result if it yields any; the priming item yields none. The
// single blend datapath emits one result per cycle while out_stall is low,
// through its product and output registers. Up to two items wait in the front
// queue, so input is taken while a run is still draining. Synchronous reset
// clears all control state and sets step_ratio to 1.0; output stalls back up
// through the blend stages into the sequencer and then the queue.
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler_unit
  import lir_pkg::*;
#(
  parameter int MAX_RUN = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step_ratio_wr_en,
  input  wire logic [PHASE_W-1:0] step_ratio,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sample_t            sample_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sample_t                 resampled,
  output logic                    last
);

  logic [PHASE_W-1:0] step;
  logic               q_valid;
  q_entry_t           q_head;
  logic               q_pop;
  logic               req_valid;
  blend_req_t         req;
  logic               req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (step_ratio_wr_en) begin
      step <= step_ratio;
    end
  end

  lir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  lir_back #(
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  lir_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .req_ready  (req_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .resampled  (resampled),
    .last       (last)
  );

endmodule

`default_nettype wire

/* tb/sv/lir_resample_checker.sv */
// Scoreboard for linear_interp_resampler_unit: tracks the step register, predicts
// the interpolated output items and compares them with what the block emits.
// Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_resample_checker
  import lir_pkg::*;
#(
  parameter int MAX_RUN = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step_ratio_wr_en,
  input  wire logic [PHASE_W-1:0] step_ratio,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire sample_t            sample_in,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire sample_t            resampled,
  input  wire logic               last,
  output int                      pending,
  output int                      fail_count
);

  typedef struct packed {
    sample_t sample;
    logic    last;
  } out_item_t;

  out_item_t          expected_out_q[$];
  logic [PHASE_W-1:0] step_q516;
  sample_t            prev_s;
  logic [PHASE_W:0]   acc_phase;  // one spare bit for the add
  logic               have_prev;
  int                 errors = 0;

  // prev*(1-t) + cur*t, t in Q0.16, truncated toward zero
  function automatic sample_t blend(sample_t a, sample_t b, logic [FRAC_W-1:0] t);
    longint acc;
    acc = longint'(a) * (longint'(PHASE_ONE) - longint'(t)) + longint'(b) * longint'(t);
    return sample_t'(acc / longint'(PHASE_ONE));
  endfunction

  task automatic interpolate_item(input sample_t cur);
    logic [PHASE_W:0] ph;
    out_item_t        held;
    int               n;
    ph = acc_phase;
    n  = 0;
    if (!have_prev) begin
      prev_s    = cur;
      have_prev = 1'b1;
      return;
    end
    // hold back one item so the final one of the run gets its last flag
    while (ph < PHASE_ONE && n < MAX_RUN) begin
      if (n > 0) expected_out_q.push_back(held);
      held.sample = blend(prev_s, cur, ph[FRAC_W-1:0]);
      held.last   = 1'b0;
      n++;
      ph = ph + step_q516;
    end
    if (n > 0) begin
      held.last = 1'b1;
      expected_out_q.push_back(held);
    end
    // ph >= one: drop by one; run cut short by the cap: phase restarts at zero
    if (ph >= PHASE_ONE) ph = ph - PHASE_ONE;
    else ph = '0;
    acc_phase = ph;
    prev_s    = cur;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      expected_out_q.delete();
      step_q516 = STEP_RESET;
      prev_s    = '0;
      acc_phase = '0;
      have_prev = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_out_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got resampled %0d last %0b",
                   $time, resampled, last);
          errors++;
        end else begin
          want = expected_out_q.pop_front();
          if (resampled !== want.sample) begin
            $display("%0t: resampled expected %0d, got %0d", $time, want.sample, resampled);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, last);
            errors++;
          end
        end
      end
      if (step_ratio_wr_en) step_q516 = step_ratio;
      if (in_valid && !in_stall) interpolate_item(sample_in);
    end
    pending    <= expected_out_q.size();
    fail_count <= errors;
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top for linear_interp_resampler_unit: clock, reset, stimulus and verdict.
// Checking is done by lir_resample_checker; depends on lir_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import lir_pkg::*;

  localparam int MAX_RUN         = 16;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 26;
  localparam int CFG_SETTLE      = 12;
  localparam int END_SETTLE      = 20;
  localparam int IDLE_LIMIT      = 1000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_t;

  logic               clk              = 1'b0;
  logic               rst              = 1'b1;
  logic               step_ratio_wr_en = 1'b0;
  logic [PHASE_W-1:0] step_ratio       = STEP_RESET;
  logic               in_valid         = 1'b0;
  sample_t            sample_in        = '0;
  logic               out_stall        = 1'b0;
  logic               in_stall;
  logic               out_valid;
  sample_t            resampled;
  logic               last;
  int                 pending;
  int                 fail_count;
  int                 src_idle_pct     = 0;
  int                 snk_stall_pct    = 0;

  linear_interp_resampler_unit #(
    .MAX_RUN(MAX_RUN)
  ) uut (
    .clk              (clk),
    .rst              (rst),
    .step_ratio_wr_en (step_ratio_wr_en),
    .step_ratio       (step_ratio),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample_in        (sample_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .resampled        (resampled),
    .last             (last)
  );

  lir_resample_checker #(
    .MAX_RUN(MAX_RUN)
  ) chk (
    .clk              (clk),
    .rst              (rst),
    .step_ratio_wr_en (step_ratio_wr_en),
    .step_ratio       (step_ratio),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample_in        (sample_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .resampled        (resampled),
    .last             (last),
    .pending          (pending),
    .fail_count       (fail_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (snk_stall_pct > 0) && ($urandom_range(99) < snk_stall_pct);
  end

  // ends the run if neither channel moves an item for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL linear_interp_resampler_unit");
    $finish;
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return sample_t'(16'h8000);
      1: return sample_t'(16'h7FFF);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [PHASE_W-1:0] plan_step(int k);
    case (k)
      0: return PHASE_W'(4096);      // exactly sixteen items per input
      1: return PHASE_W'(1048576);   // 16.0, mostly silent inputs
      2: return PHASE_W'(32768);
      3: return PHASE_W'(0);         // cap hit with phase still below one
      4: return PHASE_W'(98304);
      5: return PHASE_W'(1);
      7: return STEP_RESET;
      9: return {PHASE_W{1'b1}};     // largest step the register holds
      default: return PHASE_W'($urandom_range(1048576, 4096));
    endcase
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
      IDLE_SRC:  begin src_idle_pct <= 64; snk_stall_pct <= 0;  end
      IDLE_SNK:  begin src_idle_pct <= 0;  snk_stall_pct <= 64; end
      default:   begin src_idle_pct <= 30; snk_stall_pct <= 30; end
    endcase
  endtask

  // called at a clock edge; returns at the edge where the item is taken
  task automatic send_item(input sample_t s);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_step(input logic [PHASE_W-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    // silent inputs may still be in flight
    repeat (CFG_SETTLE) @(posedge clk);
    step_ratio_wr_en <= 1'b1;
    step_ratio       <= v;
    @(posedge clk);
    step_ratio_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset ratio of 1.0; first item only primes
    send_item(sample_t'(16'h8000));
    send_item(sample_t'(16'h7FFF));
    send_item(sample_t'(16'h8000));
    send_item(sample_t'(16'h7FFF));
    send_item(sample_t'(16'h0000));
    send_item(sample_t'(16'hFFFF));
    send_item(sample_t'(16'h0001));
    send_item(sample_t'(16'h5555));
    send_item(sample_t'(16'hAAAA));
    send_item(sample_t'(16'h7FFF));
    send_item(sample_t'(16'h7FFF));

    for (int k = 0; k < PHASES; k++) begin
      write_step(plan_step(k));
      set_idle(idle_mode_t'(k % 4));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(39) == 0) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_item(pick_sample());
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS linear_interp_resampler_unit");
    end else begin
      $display("FAIL linear_interp_resampler_unit");
    end
    $finish;
  end

endmodule
